// File: hdl/pbws_pkg.sv
// Shared types and constants for the periodic box wrap splitter.
`default_nettype none
package pbws_pkg;

  localparam int MAX_PIECES = 27;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int PASS_LIMIT = 64;
  localparam int NUM_AXES = 3;
  localparam int FIELD_W = 32;
  localparam int SIZE_W = 30;
  localparam int MASK_W = 3;
  localparam int DIMS_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W = 6 * FIELD_W;
  localparam int OUT_TDATA_W = 9 * FIELD_W;
  localparam int ROW_FIELDS = 9;
  localparam int IDX_W = $clog2(MAX_PIECES);
  localparam int CNT_W = $clog2(MAX_PIECES + 1);
  localparam int PASS_W = $clog2(PASS_LIMIT + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X        = 3'd0,
    REG_SIZE_Y        = 3'd1,
    REG_SIZE_Z        = 3'd2,
    REG_PERIODIC_MASK = 3'd3,
    REG_DIMS_USED     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // what one axis step does to the working piece
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CUT_LO,
    ACT_CUT_HI,
    ACT_UP,
    ACT_DOWN
  } action_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INPUT,
    WR_CLONE,
    WR_WORK
  } wr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_LOAD,
    ST_AXIS,
    ST_WB,
    ST_PASS_END,
    ST_EM_RD,
    ST_EM_LOAD,
    ST_EM_HOLD
  } state_t;

  typedef struct packed {
    logic             load_in;
    wr_sel_t          wr_sel;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             work_load;
    logic             work_update;
    axis_t            axis;
    logic             out_load;
    logic             out_last;
    logic             out_ovf;
  } pbws_cmd_t;

  typedef struct packed {
    logic    in_domain;
    action_t action;
  } pbws_sts_t;

endpackage
`default_nettype wire

// File: hdl/periodic_box_wrap_splitter_unit.sv
// Top level of the periodic box wrap splitter: controller plus datapath.
// Flow: a box inside the domain goes from the check state straight to emission of its word.
// Otherwise each pass walks every listed piece (read, load, x/y/z, write back) and then
// ends; passes repeat until one changes nothing (64 at most) or the list overflows.
// Each piece is then read, loaded and held until taken; next box after the last word.
// Reset (rst, synchronous): controller idle, sizes 1, no periodic axes, 3 dims.
`default_nettype none
module periodic_box_wrap_splitter_unit #(
  parameter int COORD_WIDTH = pbws_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [pbws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pbws_pkg::SIZE_W-1:0]      cfg_data,
  // box in
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z (32 bits each)
  input  wire logic [pbws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // pieces out
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // piece_lo_x/y/z, piece_hi_x/y/z, shift_x/y/z (32 bits each)
  output logic [pbws_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,  // last_piece
  output logic [0:0]                            m_axis_tuser   // overflow
);
  import pbws_pkg::*;

  pbws_cmd_t cmd;
  pbws_sts_t sts;
  logic      out_ovf;

  // sequencing: passes over the piece list, then one word per piece
  pbws_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // piece RAM, per-axis cut/move arithmetic and the output word register
  pbws_datapath #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast),
    .out_ovf  (out_ovf)
  );

  assign m_axis_tuser = out_ovf;

endmodule
`default_nettype wire

// File: hdl/pbws_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/pbws_datapath.sv
// Datapath: config registers, piece RAM, working piece, axis arithmetic, output register.
`default_nettype none
module pbws_datapath #(
  parameter int COORD_WIDTH = pbws_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pbws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pbws_pkg::SIZE_W-1:0]     cfg_data,
  input  wire logic [pbws_pkg::IN_TDATA_W-1:0] in_data,
  input  wire pbws_pkg::pbws_cmd_t             cmd,
  output pbws_pkg::pbws_sts_t                  sts,
  output logic [pbws_pkg::OUT_TDATA_W-1:0]     out_data,
  output logic                                 out_last,
  output logic                                 out_ovf
);
  import pbws_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int ROW_W = ROW_FIELDS * W;
  // compare width: holds any coordinate and any size as a signed value
  localparam int CMPW = ((W > SIZE_W) ? W : SIZE_W) + 1;

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [MASK_W-1:0] periodic_mask;
  logic [DIMS_W-1:0] dims_used;

  logic [ROW_W-1:0] work;
  logic [ROW_W-1:0] work_next;
  logic [ROW_W-1:0] clone_row;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] wdata;
  logic [ROW_W-1:0] out_row;
  logic             ram_we;
  logic [IDX_W-1:0] raddr;
  logic             in_domain;
  logic             inside_in;

  logic [SIZE_W-1:0] size_sel;
  logic [W-1:0]      sw;
  logic [W-1:0]      lo, hi, sh;
  logic              axis_en;
  logic              lo_neg, hi_pos, lo_lt_s, s_lt_hi;
  action_t           action;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x        <= SIZE_W'(1);
      size_y        <= SIZE_W'(1);
      size_z        <= SIZE_W'(1);
      periodic_mask <= '0;
      dims_used     <= DIMS_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X:        size_x        <= cfg_data;
        REG_SIZE_Y:        size_y        <= cfg_data;
        REG_SIZE_Z:        size_z        <= cfg_data;
        REG_PERIODIC_MASK: periodic_mask <= cfg_data[MASK_W-1:0];
        REG_DIMS_USED:     dims_used     <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // input word into a piece row, shifts zero; fast inside test on all axes
  always_comb begin
    logic [W-1:0] c_lo, c_hi;
    logic [SIZE_W-1:0] s_k;
    in_row    = '0;
    inside_in = 1'b1;
    for (int k = 0; k < 6; k++) begin
      in_row[k*W +: W] = W'($signed(in_data[k*FIELD_W +: FIELD_W]));
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      c_lo = in_row[k*W +: W];
      c_hi = in_row[(k+3)*W +: W];
      s_k  = (k == 0) ? size_x : ((k == 1) ? size_y : size_z);
      if (c_lo[W-1] || ($signed(CMPW'(s_k)) < $signed(CMPW'($signed(c_hi))))) begin
        inside_in = 1'b0;
      end
    end
  end

  // axis step on the working piece
  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin size_sel = size_x; axis_en = periodic_mask[0]; end
      AXIS_Y:  begin size_sel = size_y; axis_en = periodic_mask[1]; end
      AXIS_Z:  begin size_sel = size_z; axis_en = periodic_mask[2]; end
      default: begin size_sel = size_z; axis_en = 1'b0; end
    endcase
    axis_en = axis_en && (DIMS_W'(cmd.axis) < dims_used);
    sw = W'(size_sel);
    lo = work[cmd.axis*W +: W];
    hi = work[(cmd.axis+3)*W +: W];
    sh = work[(cmd.axis+6)*W +: W];
    lo_neg  = lo[W-1];
    hi_pos  = !hi[W-1] && (hi != '0);
    lo_lt_s = $signed(CMPW'($signed(lo))) < $signed(CMPW'(size_sel));
    s_lt_hi = $signed(CMPW'(size_sel)) < $signed(CMPW'($signed(hi)));
    priority if (!axis_en)           action = ACT_NONE;
    else if (lo_neg && hi_pos)       action = ACT_CUT_LO;
    else if (lo_lt_s && s_lt_hi)     action = ACT_CUT_HI;
    else if (lo_neg)                 action = ACT_UP;
    else if (s_lt_hi)                action = ACT_DOWN;
    else                             action = ACT_NONE;

    work_next = work;
    clone_row = work;
    unique case (action)
      ACT_CUT_LO: begin
        work_next[cmd.axis*W +: W]     = '0;
        clone_row[cmd.axis*W +: W]     = lo + sw;
        clone_row[(cmd.axis+3)*W +: W] = sw;
        clone_row[(cmd.axis+6)*W +: W] = sh + sw;
      end
      ACT_CUT_HI: begin
        work_next[(cmd.axis+3)*W +: W] = sw;
        clone_row[cmd.axis*W +: W]     = '0;
        clone_row[(cmd.axis+3)*W +: W] = hi - sw;
        clone_row[(cmd.axis+6)*W +: W] = sh - sw;
      end
      ACT_UP: begin
        work_next[cmd.axis*W +: W]     = lo + sw;
        work_next[(cmd.axis+3)*W +: W] = hi + sw;
        work_next[(cmd.axis+6)*W +: W] = sh + sw;
      end
      ACT_DOWN: begin
        work_next[cmd.axis*W +: W]     = lo - sw;
        work_next[(cmd.axis+3)*W +: W] = hi - sw;
        work_next[(cmd.axis+6)*W +: W] = sh - sw;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.work_load) begin
      work <= rdata;
    end else if (cmd.work_update) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_domain <= 1'b0;
    end else if (cmd.load_in) begin
      in_domain <= inside_in;
    end
  end

  // piece list storage, one row per piece
  always_comb begin
    ram_we = 1'b1;
    unique case (cmd.wr_sel)
      WR_INPUT: wdata = in_row;
      WR_CLONE: wdata = clone_row;
      WR_WORK:  wdata = work;
      default: begin
        wdata  = work;
        ram_we = 1'b0;
      end
    endcase
  end

  assign raddr = cmd.rd_addr;

  pbws_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_PIECES)
  ) u_piece_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.wr_addr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row  <= rdata;
      out_last <= cmd.out_last;
      out_ovf  <= cmd.out_ovf;
    end
  end

  always_comb begin
    for (int k = 0; k < ROW_FIELDS; k++) begin
      out_data[k*FIELD_W +: FIELD_W] = FIELD_W'($signed(out_row[k*W +: W]));
    end
  end

  assign sts.in_domain = in_domain;
  assign sts.action    = action;

endmodule
`default_nettype wire

// File: hdl/pbws_ctrl.sv
// Controller: pass, piece and axis sequencing plus result emission.
`default_nettype none
module pbws_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire pbws_pkg::pbws_sts_t  sts,
  output pbws_pkg::pbws_cmd_t       cmd
);
  import pbws_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  idx, idx_next;
  axis_t             axis, axis_next;
  logic [PASS_W-1:0] passes, passes_next;
  logic              changed, changed_next;
  logic              ovf, ovf_next;
  logic [IDX_W-1:0]  emit_idx, emit_idx_next;

  logic              is_cut, is_move, room;
  logic [CNT_W-1:0]  idx_inc;
  logic [PASS_W-1:0] passes_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      idx      <= '0;
      axis     <= AXIS_X;
      passes   <= '0;
      changed  <= 1'b0;
      ovf      <= 1'b0;
      emit_idx <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      idx      <= idx_next;
      axis     <= axis_next;
      passes   <= passes_next;
      changed  <= changed_next;
      ovf      <= ovf_next;
      emit_idx <= emit_idx_next;
    end
  end

  assign is_cut     = (sts.action == ACT_CUT_LO) || (sts.action == ACT_CUT_HI);
  assign is_move    = (sts.action == ACT_UP) || (sts.action == ACT_DOWN);
  assign room       = count < CNT_W'(MAX_PIECES);
  assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
  assign passes_inc = passes + PASS_W'(1);

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    axis_next     = axis;
    passes_next   = passes;
    changed_next  = changed;
    ovf_next      = ovf;
    emit_idx_next = emit_idx;

    cmd             = '0;
    cmd.wr_sel      = WR_NONE;
    cmd.axis        = axis;
    cmd.rd_addr     = idx;
    cmd.wr_addr     = idx;
    cmd.out_ovf     = ovf;
    cmd.out_last    = (CNT_W'(emit_idx) + CNT_W'(1)) == count;
    s_axis_tready   = 1'b0;
    m_axis_tvalid   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          cmd.wr_sel  = WR_INPUT;
          cmd.wr_addr = '0;
          count_next  = CNT_W'(1);
          ovf_next    = 1'b0;
          passes_next = '0;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        emit_idx_next = '0;
        idx_next      = '0;
        changed_next  = 1'b0;
        state_next    = sts.in_domain ? ST_EM_RD : ST_RD;
      end
      ST_RD: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.work_load = 1'b1;
        axis_next     = AXIS_X;
        state_next    = ST_AXIS;
      end
      ST_AXIS: begin
        if (is_cut && !room) begin
          // list full: stop here, keep what the piece has so far
          ovf_next   = 1'b1;
          state_next = ST_WB;
        end else begin
          if (is_cut) begin
            cmd.wr_sel  = WR_CLONE;
            cmd.wr_addr = count[IDX_W-1:0];
            count_next  = count + CNT_W'(1);
          end
          if (is_cut || is_move) begin
            cmd.work_update = 1'b1;
            changed_next    = 1'b1;
          end
          if (axis == AXIS_Z) begin
            state_next = ST_WB;
          end else begin
            axis_next = axis_t'(axis + 2'd1);
          end
        end
      end
      ST_WB: begin
        cmd.wr_sel = WR_WORK;
        if (ovf) begin
          emit_idx_next = '0;
          state_next    = ST_EM_RD;
        end else if (idx_inc < count) begin
          idx_next   = idx_inc[IDX_W-1:0];
          state_next = ST_RD;
        end else begin
          state_next = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        passes_next   = passes_inc;
        emit_idx_next = '0;
        if (changed && (passes_inc >= PASS_W'(PASS_LIMIT))) begin
          ovf_next   = 1'b1;
          state_next = ST_EM_RD;
        end else if (changed) begin
          changed_next = 1'b0;
          idx_next     = '0;
          state_next   = ST_RD;
        end else begin
          state_next = ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        cmd.rd_addr = emit_idx;
        state_next  = ST_EM_LOAD;
      end
      ST_EM_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EM_HOLD;
      end
      ST_EM_HOLD: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if ((CNT_W'(emit_idx) + CNT_W'(1)) == count) begin
            state_next = ST_IDLE;
          end else begin
            emit_idx_next = emit_idx + IDX_W'(1);
            state_next    = ST_EM_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PIECES))
    else $error("piece count past limit");

  a_clone_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sel == WR_CLONE) |-> (count < CNT_W'(MAX_PIECES)))
    else $error("clone written with list full");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EM_RD) |-> (CNT_W'(emit_idx) < count))
    else $error("emit index beyond piece count");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a word is pending");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    passes <= PASS_W'(PASS_LIMIT))
    else $error("pass counter past limit");
`endif

endmodule
`default_nettype wire
